[rtl/pra_pkg.sv]
package pra_pkg;

  localparam int MAX_REGIONS = 64;
  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = IDX_W + 1;

  // operation codes
  localparam logic [2:0] FN_ALLOC_LO = 3'd0;
  localparam logic [2:0] FN_ALLOC_HI = 3'd1;
  localparam logic [2:0] FN_ALLOC_AT = 3'd2;
  localparam logic [2:0] FN_FREE     = 3'd3;
  localparam logic [2:0] FN_FIND     = 3'd4;
  localparam logic [2:0] FN_INIT     = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FIT   = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_NOT_FND  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic        used;
    logic [31:0] size;
    logic [31:0] start;
  } entry_t;

endpackage

[rtl/pra_table.sv]
module pra_table (
  input  logic                      clk,
  input  logic                      we,
  input  logic [pra_pkg::IDX_W-1:0] waddr,
  input  pra_pkg::entry_t           wdata,
  input  logic [pra_pkg::IDX_W-1:0] raddr,
  output pra_pkg::entry_t           rdata
);
  import pra_pkg::*;

  entry_t mem [MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/page_region_allocator_unit.sv]
// Page region allocator: keeps an address-ordered table of up to MAX_REGIONS
// regions (start, size, used mark) in a one-port-read / one-port-write table
// memory, plus a running byte count. One item per request, one item per
// result. An item passes through dispatch, a table scan in which each entry is
// read, then evaluated, up to two neighbor reads plus a merge step on a free, a
// read and a write per entry moved when a split or merge shifts the table, up
// to three final entry writes, and a result step that can wait on m_tready.
// The single table read port sets the pace; a new request is taken only once
// the block is back in S_IDLE. Init, zero-length and empty-table requests skip
// the scan. The user must write page_shift through cfg_* only while the block
// is idle; the block itself does not enforce this.
module page_region_allocator_unit (
  input  logic          clk,
  input  logic          rst,
  // config: page_shift[4:0]
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [4:0]    cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [63:0]   s_tdata,   // address[31:0], length[63:32]
  input  logic [2:0]    s_tuser,   // func[2:0]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // region_start[31:0], region_size[63:32],
                                   // region_in_use[64], total_used[96:65], zero pad
  output logic [2:0]    m_tuser    // status[2:0]
);
  import pra_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_PREV_RD, S_PREV_EV, S_NEXT_RD, S_NEXT_EV,
    S_MERGE, S_SH_RD, S_SH_WR, S_WR, S_DONE
  } state_t;

  state_t             state;
  logic [4:0]         page_shift;
  logic [2:0]         func_r;
  logic [31:0]        addr_r;
  logic [31:0]        addr_al;
  logic [33:0]        sz;
  logic [CNT_W-1:0]   count;
  logic [31:0]        used_bytes;
  logic [CNT_W-1:0]   ptr;
  logic [CNT_W-1:0]   scan_left;
  entry_t             cur;
  entry_t             prv;
  entry_t             nxt;
  logic               prev_ok;
  logic               next_ok;
  logic [CNT_W-1:0]   sh_src;
  logic [CNT_W-1:0]   sh_n;
  logic [1:0]         sh_k;
  logic               sh_up;
  logic [CNT_W-1:0]   wbase;
  entry_t             wd [3];
  logic [1:0]         wn;
  logic [1:0]         wi;
  logic [2:0]         res_status;
  logic               res_ok;
  entry_t             res_e;

  // table port
  logic               t_we;
  logic [IDX_W-1:0]   t_waddr;
  entry_t             t_wdata;
  logic [IDX_W-1:0]   t_raddr;
  entry_t             rdata;

  pra_table u_table (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (rdata)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);

  // input-side arithmetic
  logic [31:0] in_addr, in_len;
  logic [33:0] pm34;
  logic [33:0] sz_lo, sz_at;
  logic [31:0] in_al;
  logic [31:0] init_lim, init_sz;
  assign in_addr  = s_tdata[31:0];
  assign in_len   = s_tdata[63:32];
  assign pm34     = (34'd1 << page_shift) - 34'd1;
  assign sz_lo    = ({2'b0, in_len} + pm34) & ~pm34;
  assign sz_at    = ({2'b0, in_len} + {2'b0, in_addr & pm34[31:0]} + pm34) & ~pm34;
  assign in_al    = in_addr & ~pm34[31:0];
  assign init_lim = ~in_addr;
  assign init_sz  = (in_len < init_lim) ? in_len : init_lim;

  // scan evaluation on the entry just read
  logic [32:0]      ent_end;
  logic [33:0]      a_end;
  logic             is_alloc;
  logic             ev_match;
  logic             at_bad;
  logic [31:0]      before_sz, after_sz;
  logic             nb, na;
  logic [1:0]       k_at;
  logic [CNT_W-1:0] ptr_p1, ptr_m1, moves_up;
  entry_t           e_used, e_rem, e_main, e_before, e_after;

  assign ent_end  = {1'b0, rdata.start} + {1'b0, rdata.size};
  assign a_end    = {2'b0, addr_al} + sz;
  assign is_alloc = (func_r == FN_ALLOC_LO) || (func_r == FN_ALLOC_HI) ||
                    (func_r == FN_ALLOC_AT);
  assign ptr_p1   = ptr + 1'b1;
  assign ptr_m1   = ptr - 1'b1;
  assign moves_up = count - ptr_p1;

  always_comb begin
    case (func_r)
      FN_ALLOC_LO, FN_ALLOC_HI: ev_match = !rdata.used && ({2'b0, rdata.size} >= sz);
      FN_ALLOC_AT:              ev_match = (ent_end > {1'b0, addr_al});
      FN_FREE, FN_FIND:         ev_match = (addr_r >= rdata.start) &&
                                           ({1'b0, addr_r} < ent_end);
      default:                  ev_match = 1'b0;
    endcase
  end

  assign at_bad    = (rdata.start > addr_al) || ({1'b0, ent_end} < a_end) || rdata.used;
  assign before_sz = addr_al - rdata.start;
  assign after_sz  = ent_end[31:0] - a_end[31:0];
  assign nb        = (before_sz != 32'd0);
  assign na        = (after_sz != 32'd0);
  assign k_at      = {1'b0, nb} + {1'b0, na};

  // split pieces: low-end alloc keeps used part first, high-end keeps it last
  always_comb begin
    e_used   = '{used: 1'b1, size: sz[31:0], start: rdata.start};
    e_rem    = '{used: 1'b0, size: rdata.size - sz[31:0],
                 start: rdata.start + sz[31:0]};
    if (func_r == FN_ALLOC_HI) begin
      e_rem  = '{used: 1'b0, size: rdata.size - sz[31:0], start: rdata.start};
      e_used = '{used: 1'b1, size: sz[31:0],
                 start: rdata.start + rdata.size - sz[31:0]};
    end
    e_main   = '{used: 1'b1, size: sz[31:0], start: addr_al};
    e_before = '{used: 1'b0, size: before_sz, start: rdata.start};
    e_after  = '{used: 1'b0, size: after_sz, start: a_end[31:0]};
  end

  // free: merged region
  logic [31:0]      mg_size;
  logic [1:0]       k_fr;
  logic [CNT_W-1:0] fr_lo;
  entry_t           e_merged;
  assign mg_size  = (prev_ok ? prv.size : 32'd0) + cur.size + (next_ok ? nxt.size : 32'd0);
  assign e_merged = '{used: 1'b0, size: mg_size, start: prev_ok ? prv.start : cur.start};
  assign k_fr     = {1'b0, prev_ok} + {1'b0, next_ok};
  assign fr_lo    = ptr_p1 + {{(CNT_W-1){1'b0}}, next_ok};

  logic [CNT_W-1:0] sh_dst, w_addr;
  assign sh_dst = sh_up ? (sh_src + {{(CNT_W-2){1'b0}}, sh_k})
                        : (sh_src - {{(CNT_W-2){1'b0}}, sh_k});
  assign w_addr = wbase + {{(CNT_W-2){1'b0}}, wi};

  always_comb begin
    t_we    = 1'b0;
    t_waddr = '0;
    t_wdata = rdata;
    t_raddr = ptr[IDX_W-1:0];
    case (state)
      S_PREV_RD: t_raddr = ptr_m1[IDX_W-1:0];
      S_NEXT_RD: t_raddr = ptr_p1[IDX_W-1:0];
      S_SH_RD:   t_raddr = sh_src[IDX_W-1:0];
      S_SH_WR: begin
        t_we    = 1'b1;
        t_waddr = sh_dst[IDX_W-1:0];
      end
      S_WR: begin
        t_we    = 1'b1;
        t_waddr = w_addr[IDX_W-1:0];
        t_wdata = wd[wi];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      page_shift <= 5'd12;
      count      <= '0;
      used_bytes <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        page_shift <= cfg_data;
      end
      // a result leaving in S_DONE is replaced there
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func_r     <= s_tuser;
            addr_r     <= in_addr;
            addr_al    <= in_al;
            sz         <= (s_tuser == FN_ALLOC_AT) ? sz_at : sz_lo;
            res_ok     <= (s_tuser == FN_INIT) && (init_sz != 32'd0);
            scan_left  <= count;
            ptr        <= (s_tuser == FN_ALLOC_HI) ? count - 1'b1 : '0;
            wi         <= '0;
            case (s_tuser)
              FN_ALLOC_LO, FN_ALLOC_HI, FN_ALLOC_AT: begin
                if (in_len == 32'd0) begin
                  res_status <= ST_ZERO;
                  state      <= S_DONE;
                end else if (count == '0) begin
                  res_status <= ST_NO_FIT;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              FN_FREE, FN_FIND: begin
                if (count == '0) begin
                  res_status <= ST_NOT_FND;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              FN_INIT: begin
                used_bytes <= '0;
                if (init_sz == 32'd0) begin
                  count      <= '0;
                  res_status <= ST_ZERO;
                  state      <= S_DONE;
                end else begin
                  wd[0]      <= '{used: 1'b0, size: init_sz, start: in_addr};
                  res_e      <= '{used: 1'b0, size: init_sz, start: in_addr};
                  wbase      <= '0;
                  wn         <= 2'd1;
                  count      <= {{(CNT_W-1){1'b0}}, 1'b1};
                  res_status <= ST_OK;
                  state      <= S_WR;
                end
              end
              default: begin
                res_status <= ST_NOT_FND;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN_RD: state <= S_SCAN_EV;
        S_SCAN_EV: begin
          if (ev_match) begin
            case (func_r)
              FN_ALLOC_LO, FN_ALLOC_HI: begin
                if ({2'b0, rdata.size} == sz) begin
                  wd[0]      <= '{used: 1'b1, size: rdata.size, start: rdata.start};
                  res_e      <= '{used: 1'b1, size: rdata.size, start: rdata.start};
                  wbase      <= ptr;
                  wn         <= 2'd1;
                  used_bytes <= used_bytes + sz[31:0];
                  res_status <= ST_OK;
                  res_ok     <= 1'b1;
                  state      <= S_WR;
                end else if (count >= CNT_W'(MAX_REGIONS)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  wd[0]      <= (func_r == FN_ALLOC_LO) ? e_used : e_rem;
                  wd[1]      <= (func_r == FN_ALLOC_LO) ? e_rem : e_used;
                  res_e      <= e_used;
                  wbase      <= ptr;
                  wn         <= 2'd2;
                  sh_src     <= count - 1'b1;
                  sh_n       <= moves_up;
                  sh_k       <= 2'd1;
                  sh_up      <= 1'b1;
                  count      <= count + 1'b1;
                  used_bytes <= used_bytes + sz[31:0];
                  res_status <= ST_OK;
                  res_ok     <= 1'b1;
                  state      <= (moves_up == '0) ? S_WR : S_SH_RD;
                end
              end
              FN_ALLOC_AT: begin
                if (at_bad) begin
                  res_status <= ST_NO_FIT;
                  state      <= S_DONE;
                end else if (({1'b0, count} + {{(CNT_W-1){1'b0}}, k_at}) >
                             (CNT_W+1)'(MAX_REGIONS)) begin
                  res_status <= ST_FULL;
                  state      <= S_DONE;
                end else begin
                  wd[0]      <= nb ? e_before : e_main;
                  wd[1]      <= nb ? e_main : e_after;
                  wd[2]      <= e_after;
                  res_e      <= e_main;
                  wbase      <= ptr;
                  wn         <= k_at + 2'd1;
                  sh_src     <= count - 1'b1;
                  sh_n       <= (k_at == 2'd0) ? '0 : moves_up;
                  sh_k       <= k_at;
                  sh_up      <= 1'b1;
                  count      <= count + {{(CNT_W-2){1'b0}}, k_at};
                  used_bytes <= used_bytes + sz[31:0];
                  res_status <= ST_OK;
                  res_ok     <= 1'b1;
                  state      <= ((k_at == 2'd0) || (moves_up == '0)) ? S_WR : S_SH_RD;
                end
              end
              FN_FIND: begin
                res_e      <= rdata;
                res_status <= ST_OK;
                res_ok     <= 1'b1;
                state      <= S_DONE;
              end
              default: begin
                // free
                if (!rdata.used) begin
                  res_status <= ST_NOT_FND;
                  state      <= S_DONE;
                end else begin
                  cur     <= rdata;
                  prev_ok <= 1'b0;
                  next_ok <= 1'b0;
                  if (ptr != '0) begin
                    state <= S_PREV_RD;
                  end else if (ptr_p1 < count) begin
                    state <= S_NEXT_RD;
                  end else begin
                    state <= S_MERGE;
                  end
                end
              end
            endcase
          end else if (scan_left == {{(CNT_W-1){1'b0}}, 1'b1}) begin
            res_status <= is_alloc ? ST_NO_FIT : ST_NOT_FND;
            state      <= S_DONE;
          end else begin
            scan_left <= scan_left - 1'b1;
            ptr       <= (func_r == FN_ALLOC_HI) ? ptr_m1 : ptr_p1;
            state     <= S_SCAN_RD;
          end
        end
        S_PREV_RD: state <= S_PREV_EV;
        S_PREV_EV: begin
          prv     <= rdata;
          prev_ok <= !rdata.used && (ent_end == {1'b0, cur.start});
          state   <= (ptr_p1 < count) ? S_NEXT_RD : S_MERGE;
        end
        S_NEXT_RD: state <= S_NEXT_EV;
        S_NEXT_EV: begin
          nxt     <= rdata;
          next_ok <= !rdata.used &&
                     ({1'b0, rdata.start} == ({1'b0, cur.start} + {1'b0, cur.size}));
          state   <= S_MERGE;
        end
        S_MERGE: begin
          wd[0]      <= e_merged;
          res_e      <= e_merged;
          wbase      <= prev_ok ? ptr_m1 : ptr;
          wn         <= 2'd1;
          sh_src     <= fr_lo;
          sh_n       <= (k_fr == 2'd0) ? '0 : (count - fr_lo);
          sh_k       <= k_fr;
          sh_up      <= 1'b0;
          count      <= count - {{(CNT_W-2){1'b0}}, k_fr};
          used_bytes <= used_bytes - cur.size;
          res_status <= ST_OK;
          res_ok     <= 1'b1;
          state      <= ((k_fr == 2'd0) || (count == fr_lo)) ? S_WR : S_SH_RD;
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          sh_n <= sh_n - 1'b1;
          if (sh_n == {{(CNT_W-1){1'b0}}, 1'b1}) begin
            state <= S_WR;
          end else begin
            sh_src <= sh_up ? sh_src - 1'b1 : sh_src + 1'b1;
            state  <= S_SH_RD;
          end
        end
        S_WR: begin
          wi <= wi + 2'd1;
          if (wi == wn - 2'd1) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {7'b0, used_bytes,
                         res_ok ? res_e.used : 1'b0,
                         res_ok ? res_e.size : 32'd0,
                         res_ok ? res_e.start : 32'd0};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
